// ----- rtl/ubce_pkg.sv -----
// Shared types, constants and code tables for the bootloader command engine.
package ubce_pkg;

   localparam int BUFFER_DEPTH_DEFAULT = 256;
   localparam int TIMER_BITS_DEFAULT   = 16;

   localparam logic [7:0] ACK_BYTE  = 8'h79;
   localparam logic [7:0] NACK_BYTE = 8'h1F;
   localparam logic [7:0] CPL_OK    = 8'hFF;

   localparam logic [7:0] CMD_GET        = 8'h00;
   localparam logic [7:0] CMD_VERSION    = 8'h01;
   localparam logic [7:0] CMD_ID         = 8'h02;
   localparam logic [7:0] CMD_READ       = 8'h11;
   localparam logic [7:0] CMD_GO         = 8'h21;
   localparam logic [7:0] CMD_WRITE      = 8'h31;
   localparam logic [7:0] CMD_PAGE_ERASE = 8'h43;

   localparam logic [7:0] GET_COUNT = 8'h07;
   localparam logic [7:0] ID_COUNT  = 8'h01;

   localparam logic [7:0] KNOWN_CODES [7] = '{CMD_GET, CMD_VERSION, CMD_ID, CMD_READ,
                                              CMD_GO, CMD_WRITE, CMD_PAGE_ERASE};

   localparam logic [2:0] CSR_VERSION = 3'd0;
   localparam logic [2:0] CSR_PID     = 3'd1;
   localparam logic [2:0] CSR_TIMEOUT = 3'd2;
   localparam logic [2:0] CSR_FBASE   = 3'd3;
   localparam logic [2:0] CSR_PSHIFT  = 3'd4;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   typedef enum logic [2:0] {
      KIND_TX    = 3'd0,
      KIND_READ  = 3'd1,
      KIND_WRITE = 3'd2,
      KIND_ERASE = 3'd3,
      KIND_JUMP  = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      PH_GREET, PH_IDLE, PH_CPL, PH_ADDR, PH_RLEN, PH_COUNT, PH_DATA, PH_DRAIN
   } phase_type;

   typedef enum logic [3:0] {
      SEQ_NONE, SEQ_ACK, SEQ_NACK, SEQ_GET, SEQ_VER, SEQ_ID, SEQ_JUMP, SEQ_READ,
      SEQ_DRAIN
   } seq_type;

   typedef struct packed {
      logic [7:0]  version_code;
      logic [15:0] product_id;
      logic [15:0] timeout_ticks;
      logic [31:0] flash_base;
      logic [4:0]  page_shift;
   } cfg_type;

   // One accepted word's worth of responses, handed from control to the emitter.
   typedef struct packed {
      logic        greet;
      seq_type     seq;
      logic [31:0] addr;
      logic [8:0]  len;
      logic        ack_after;
      logic        erase;
   } desc_type;

   function automatic logic [3:0] seq_len(input seq_type s, input logic ack_after);
      logic [3:0] n;
      unique case (s)
         SEQ_NONE:  n = 4'd0;
         SEQ_ACK:   n = 4'd1;
         SEQ_NACK:  n = 4'd1;
         SEQ_GET:   n = 4'd11;
         SEQ_VER:   n = 4'd5;
         SEQ_ID:    n = 4'd5;
         SEQ_JUMP:  n = 4'd2;
         SEQ_READ:  n = 4'd2;
         SEQ_DRAIN: n = ack_after ? 4'd2 : 4'd1;
         default:   n = 4'd0;
      endcase
      return n;
   endfunction

endpackage

// ----- rtl/ubce_if.sv -----
// Valid/ready channel interfaces for command input and response output.
interface ubce_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] rx_byte;
   modport source (output valid, output op, output rx_byte, input ready);
   modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

interface ubce_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [7:0]  tx_value;
   logic [31:0] mem_address;
   logic [8:0]  read_length;
   logic        last;
   modport source (output valid, output kind, output tx_value, output mem_address,
                   output read_length, output last, input ready);
   modport sink   (input valid, input kind, input tx_value, input mem_address,
                   input read_length, input last, output ready);
endinterface

// ----- rtl/ubce_ctrl.sv -----
// Protocol state machine with the write/page buffer memory.
module ubce_ctrl import ubce_pkg::*; #(
   parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEFAULT,
   parameter int TIMER_BITS   = TIMER_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic       op,
   input  logic [7:0] rx_byte,
   input  cfg_type    cfg,
   output desc_type   desc,
   output logic [7:0] rdata
);

   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam int CW = (TIMER_BITS > 16) ? TIMER_BITS : 16;

   phase_type             phase_ff, phase_in;
   logic [7:0]            cmd_ff, cmd_in;
   logic [31:0]           taddr_ff, taddr_in;
   logic [7:0]            csum_ff, csum_in;
   logic [8:0]            bidx_ff, bidx_in;
   logic [7:0]            count_ff, count_in;
   logic [TIMER_BITS-1:0] tcnt_ff, tcnt_in;
   logic [8:0]            didx_ff, didx_in;
   logic                  mem_we;
   logic                  mem_re;
   logic [7:0]            mem [BUFFER_DEPTH];
   logic [7:0]            rdata_ff;
   phase_type             ph;
   logic [TIMER_BITS-1:0] tcnt_inc;

   assign rdata = rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[bidx_ff[AW-1:0]] <= rx_byte;
      end
      if (mem_re) begin
         rdata_ff <= mem[didx_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_GREET;
         cmd_ff   <= '0;
         taddr_ff <= '0;
         csum_ff  <= '0;
         bidx_ff  <= '0;
         count_ff <= '0;
         tcnt_ff  <= '0;
         didx_ff  <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         cmd_ff   <= cmd_in;
         taddr_ff <= taddr_in;
         csum_ff  <= csum_in;
         bidx_ff  <= bidx_in;
         count_ff <= count_in;
         tcnt_ff  <= tcnt_in;
         didx_ff  <= didx_in;
      end
   end

   assign tcnt_inc = (&tcnt_ff) ? tcnt_ff : tcnt_ff + 1'b1;

   always_comb begin
      cmd_in    = cmd_ff;
      taddr_in  = taddr_ff;
      csum_in   = csum_ff;
      bidx_in   = bidx_ff;
      count_in  = count_ff;
      tcnt_in   = tcnt_ff;
      didx_in   = didx_ff;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      desc      = '0;
      desc.seq  = SEQ_NONE;
      desc.greet = (phase_ff == PH_GREET);
      // The greeting word is otherwise handled exactly as in idle.
      ph = (phase_ff == PH_GREET) ? PH_IDLE : phase_ff;
      phase_in  = ph;
      if (op == OP_BYTE) begin
         unique case (ph)
            PH_IDLE: begin
               cmd_in   = rx_byte;
               phase_in = PH_CPL;
               bidx_in  = '0;
               tcnt_in  = '0;
            end
            PH_CPL: begin
               phase_in = PH_IDLE;
               if ((cmd_ff ^ rx_byte) != CPL_OK) begin
                  desc.seq = SEQ_NACK;
               end else begin
                  unique case (cmd_ff)
                     CMD_GET:     desc.seq = SEQ_GET;
                     CMD_VERSION: desc.seq = SEQ_VER;
                     CMD_ID:      desc.seq = SEQ_ID;
                     CMD_READ, CMD_GO, CMD_WRITE: begin
                        desc.seq = SEQ_ACK;
                        phase_in = PH_ADDR;
                        bidx_in  = '0;
                        tcnt_in  = '0;
                        csum_in  = '0;
                        taddr_in = '0;
                     end
                     CMD_PAGE_ERASE: begin
                        desc.seq = SEQ_ACK;
                        phase_in = PH_COUNT;
                     end
                     default: desc.seq = SEQ_NACK;
                  endcase
               end
            end
            PH_ADDR: begin
               if (bidx_ff < 9'd4) begin
                  taddr_in = {taddr_ff[23:0], rx_byte};
                  csum_in  = csum_ff ^ rx_byte;
                  bidx_in  = bidx_ff + 9'd1;
               end else if (rx_byte != csum_ff) begin
                  desc.seq = SEQ_NACK;
                  phase_in = PH_IDLE;
               end else if (cmd_ff == CMD_READ) begin
                  desc.seq = SEQ_ACK;
                  phase_in = PH_RLEN;
                  bidx_in  = '0;
                  tcnt_in  = '0;
               end else if (cmd_ff == CMD_GO) begin
                  desc.seq  = SEQ_JUMP;
                  desc.addr = taddr_ff;
                  phase_in  = PH_IDLE;
               end else begin
                  desc.seq = SEQ_ACK;
                  phase_in = PH_COUNT;
               end
            end
            PH_RLEN: begin
               if (bidx_ff == 9'd0) begin
                  count_in = rx_byte;
                  bidx_in  = 9'd1;
               end else if ((count_ff ^ rx_byte) != CPL_OK) begin
                  desc.seq = SEQ_NACK;
                  phase_in = PH_IDLE;
               end else begin
                  desc.seq  = SEQ_READ;
                  desc.addr = taddr_ff;
                  desc.len  = {1'b0, count_ff} + 9'd1;
                  phase_in  = PH_IDLE;
               end
            end
            PH_COUNT: begin
               count_in = rx_byte;
               if (cmd_ff == CMD_PAGE_ERASE && rx_byte == CPL_OK) begin
                  desc.seq = SEQ_NACK;
                  phase_in = PH_IDLE;
               end else begin
                  phase_in = PH_DATA;
                  bidx_in  = '0;
                  tcnt_in  = '0;
                  csum_in  = rx_byte;
               end
            end
            PH_DATA: begin
               if (bidx_ff <= {1'b0, count_ff}) begin
                  mem_we  = accept;
                  csum_in = csum_ff ^ rx_byte;
                  bidx_in = bidx_ff + 9'd1;
               end else if (rx_byte != csum_ff) begin
                  desc.seq = SEQ_NACK;
                  phase_in = PH_IDLE;
               end else begin
                  phase_in = PH_DRAIN;
                  didx_in  = '0;
               end
            end
            default: ;
         endcase
      end else begin
         priority case (ph)
            PH_CPL, PH_ADDR, PH_RLEN, PH_DATA: begin
               tcnt_in = tcnt_inc;
               if (CW'(tcnt_inc) >= CW'(cfg.timeout_ticks)) begin
                  phase_in = PH_IDLE;
                  if (ph != PH_CPL) begin
                     desc.seq = SEQ_NACK;
                  end
               end
            end
            PH_DRAIN: begin
               // The buffer entry is read at this edge and held for the emitter.
               mem_re         = accept;
               desc.seq       = SEQ_DRAIN;
               desc.erase     = (cmd_ff == CMD_PAGE_ERASE);
               desc.addr      = taddr_ff + {23'd0, didx_ff};
               didx_in        = didx_ff + 9'd1;
               desc.ack_after = (didx_in > {1'b0, count_ff});
               if (desc.ack_after) begin
                  phase_in = PH_IDLE;
               end
            end
            default: ;
         endcase
      end
   end

endmodule

// ----- rtl/ubce_emit.sv -----
// Response sequencer: expands one descriptor into a run of result words.
module ubce_emit import ubce_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_fire,
   input  desc_type   desc,
   input  logic [7:0] rdata,
   input  cfg_type    cfg,
   output logic       req_ready,
   ubce_rsp_if.source rsp
);

   logic       busy_ff, busy_in;
   desc_type   desc_ff;
   logic [3:0] pos_ff, pos_in;
   logic [3:0] total_ff;
   logic [3:0] total;
   logic [3:0] q;
   logic       final_word;
   logic       load;
   logic [31:0] erase_addr;

   assign total      = seq_len(desc.seq, desc.ack_after) + {3'd0, desc.greet};
   assign load       = req_fire && (total != 4'd0);
   assign final_word = (pos_ff == total_ff - 4'd1);
   assign req_ready  = !busy_ff || (rsp.ready && final_word);

   always_comb begin
      busy_in = busy_ff;
      pos_in  = pos_ff;
      if (busy_ff && rsp.ready) begin
         pos_in = pos_ff + 4'd1;
         if (final_word) begin
            busy_in = 1'b0;
         end
      end
      if (load) begin
         busy_in = 1'b1;
         pos_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         pos_ff  <= pos_in;
      end
      if (load) begin
         desc_ff  <= desc;
         total_ff <= total;
      end
   end

   assign q          = pos_ff - {3'd0, desc_ff.greet};
   assign erase_addr = cfg.flash_base + ({24'd0, rdata} << cfg.page_shift);

   always_comb begin
      rsp.valid       = busy_ff;
      rsp.last        = final_word;
      rsp.kind        = KIND_TX;
      rsp.tx_value    = ACK_BYTE;
      rsp.mem_address = '0;
      rsp.read_length = '0;
      if (!(desc_ff.greet && pos_ff == 4'd0)) begin
         unique case (desc_ff.seq)
            SEQ_NACK: rsp.tx_value = NACK_BYTE;
            SEQ_GET: begin
               if (q == 4'd1) begin
                  rsp.tx_value = GET_COUNT;
               end else if (q == 4'd2) begin
                  rsp.tx_value = cfg.version_code;
               end else if (q >= 4'd3 && q <= 4'd9) begin
                  rsp.tx_value = KNOWN_CODES[3'(q - 4'd3)];
               end
            end
            SEQ_VER: begin
               if (q == 4'd1) begin
                  rsp.tx_value = cfg.version_code;
               end else if (q == 4'd2 || q == 4'd3) begin
                  rsp.tx_value = 8'd0;
               end
            end
            SEQ_ID: begin
               if (q == 4'd1) begin
                  rsp.tx_value = ID_COUNT;
               end else if (q == 4'd2) begin
                  rsp.tx_value = cfg.product_id[15:8];
               end else if (q == 4'd3) begin
                  rsp.tx_value = cfg.product_id[7:0];
               end
            end
            SEQ_JUMP: begin
               if (q == 4'd1) begin
                  rsp.kind        = KIND_JUMP;
                  rsp.tx_value    = 8'd0;
                  rsp.mem_address = desc_ff.addr;
               end
            end
            SEQ_READ: begin
               if (q == 4'd1) begin
                  rsp.kind        = KIND_READ;
                  rsp.tx_value    = 8'd0;
                  rsp.mem_address = desc_ff.addr;
                  rsp.read_length = desc_ff.len;
               end
            end
            SEQ_DRAIN: begin
               if (q == 4'd0) begin
                  if (desc_ff.erase) begin
                     rsp.kind        = KIND_ERASE;
                     rsp.tx_value    = 8'd0;
                     rsp.mem_address = erase_addr;
                  end else begin
                     rsp.kind        = KIND_WRITE;
                     rsp.tx_value    = rdata;
                     rsp.mem_address = desc_ff.addr;
                  end
               end
            end
            default: ;
         endcase
      end
   end

endmodule

// ----- rtl/uart_bootloader_command_engine_top.sv -----
// Top level of the serial bootloader command engine.
// Each input word is a received byte or a time tick; the engine checks command and
// complement pairs, address and data checksums, buffers write data or erase page lists
// in a BUFFER_DEPTH-byte memory (256 by default), and answers with ACK/NACK bytes and
// memory actions. A word is taken when the response sequencer is free or is passing on
// the last result of its run; the word then yields one result per cycle while the
// output is ready. A drain tick reads its buffer byte at the accepting edge and emits
// it on the next cycle. There is no clearing pass after reset. The user must write the
// configuration through the csr port only while idle; the block does not enforce it.
module uart_bootloader_command_engine_top import ubce_pkg::*; #(
   parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEFAULT,
   parameter int TIMER_BITS   = TIMER_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   ubce_req_if.sink    req_chan,
   ubce_rsp_if.source  rsp_chan,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   cfg_type    cfg_ff;
   desc_type   desc;
   logic [7:0] rdata;
   logic       req_ready;
   logic       req_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.version_code  <= 8'd1;
         cfg_ff.product_id    <= 16'd1088;
         cfg_ff.timeout_ticks <= 16'd1000;
         cfg_ff.flash_base    <= 32'h0800_0000;
         cfg_ff.page_shift    <= 5'd10;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_VERSION: cfg_ff.version_code  <= csr_wdata[7:0];
            CSR_PID:     cfg_ff.product_id    <= csr_wdata[15:0];
            CSR_TIMEOUT: cfg_ff.timeout_ticks <= csr_wdata[15:0];
            CSR_FBASE:   cfg_ff.flash_base    <= csr_wdata;
            CSR_PSHIFT:  cfg_ff.page_shift    <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   assign req_chan.ready = req_ready;
   assign req_fire       = req_chan.valid && req_ready;

   ubce_ctrl #(
      .BUFFER_DEPTH (BUFFER_DEPTH),
      .TIMER_BITS   (TIMER_BITS)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_fire),
      .op      (req_chan.op),
      .rx_byte (req_chan.rx_byte),
      .cfg     (cfg_ff),
      .desc    (desc),
      .rdata   (rdata)
   );

   ubce_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .desc      (desc),
      .rdata     (rdata),
      .cfg       (cfg_ff),
      .req_ready (req_ready),
      .rsp       (rsp_chan)
   );

endmodule

// ----- rtl/ubce_checker.sv -----
// Port-level assertions for the command engine, bound to the top level.
module ubce_checker import ubce_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_kind,
   input logic [31:0] rsp_mem_address,
   input logic [8:0]  rsp_read_length,
   input logic        rsp_last
);

   // A new word is only taken when the pending run is finishing.
   a_ready_gap: assert property (@(posedge clock) disable iff (reset)
      (req_ready && rsp_valid) |-> (rsp_ready && rsp_last))
      else $error("input taken while a response run is still pending");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_kind)))
      else $error("stalled response word changed");

   a_read_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_READ) |-> (rsp_read_length != 9'd0))
      else $error("read block with zero length");

   a_tx_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_TX) |-> (rsp_mem_address == 32'd0 && !rsp_kind[2]))
      else $error("transmit word carries an address");

endmodule

bind uart_bootloader_command_engine_top ubce_checker u_ubce_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_kind        (rsp_chan.kind),
   .rsp_mem_address (rsp_chan.mem_address),
   .rsp_read_length (rsp_chan.read_length),
   .rsp_last        (rsp_chan.last)
);
